@@ rtl/core/scpd_pkg.sv @@
package scpd_pkg;

	// register map
	localparam logic [2:0] REG_WIN_BEGIN   = 3'd0;
	localparam logic [2:0] REG_WIN_END     = 3'd1;
	localparam logic [2:0] REG_INDEX_SCALE = 3'd2;
	localparam logic [2:0] REG_CENTER_OFS  = 3'd3;
	localparam logic [2:0] REG_SETPOINT    = 3'd4;
	localparam logic [2:0] REG_PROP_GAIN   = 3'd5;
	localparam logic [2:0] REG_DERIV_GAIN  = 3'd6;

	// input op codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// restoring divider: quotient bits
	localparam int DIV_BITS = 62;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_FIN,
		ST_TICK_P,
		ST_TICK_D,
		ST_TICK_U,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;       // input word accepted
		logic acc;        // accumulate sample
		logic mark_empty; // empty window, hold centroid
		logic div_load;   // load divider, clear sums
		logic div_step;
		logic fin;
		logic tick_p;
		logic tick_d;
		logic tick_u;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic range_zero;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

@@ rtl/core/scpd_ctrl.sv @@
module scpd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             op,
	input  logic             last_beam,
	output logic             in_ready,
	input  scpd_pkg::status_t sts,
	output scpd_pkg::cmd_t    cmd
);
	import scpd_pkg::*;

	state_t state_q, state_nxt;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_TICK) state_nxt = ST_TICK_P;
					else if (last_beam) state_nxt = ST_SETUP;
				end
			end
			ST_SETUP:  state_nxt = sts.range_zero ? ST_OUT : ST_DIV;
			ST_DIV:    if (sts.div_last) state_nxt = ST_FIN;
			ST_FIN:    state_nxt = ST_OUT;
			ST_TICK_P: state_nxt = ST_TICK_D;
			ST_TICK_D: state_nxt = ST_TICK_U;
			ST_TICK_U: state_nxt = ST_OUT;
			ST_OUT:    if (sts.out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.take = accept;
				cmd.acc  = accept && (op == OP_SAMPLE);
			end
			ST_SETUP: begin
				cmd.mark_empty = sts.range_zero;
				cmd.div_load   = !sts.range_zero;
			end
			ST_DIV:    cmd.div_step = 1'b1;
			ST_FIN:    cmd.fin      = 1'b1;
			ST_TICK_P: cmd.tick_p   = 1'b1;
			ST_TICK_D: cmd.tick_d   = 1'b1;
			ST_TICK_U: cmd.tick_u   = 1'b1;
			ST_OUT:    cmd.load_out = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

@@ rtl/core/scpd_datapath.sv @@
module scpd_datapath #(
	parameter int MAX_BEAMS = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	// config
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input word
	input  logic               op,
	input  logic [15:0]        range_value,
	input  logic               last_beam,
	// output word
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic signed [14:0] centroid_norm,
	output logic signed [15:0] steering,
	output logic               empty_scan,
	output logic               clamped,
	// control
	input  scpd_pkg::cmd_t     cmd,
	output scpd_pkg::status_t  sts
);
	import scpd_pkg::*;

	localparam int CW = $clog2(MAX_BEAMS);

	// config registers
	logic        [10:0] win_begin_q, win_end_q, index_scale_q;
	logic signed [14:0] center_ofs_q, setpoint_q;
	logic        [15:0] prop_gain_q, deriv_gain_q;

	// scan state
	logic [CW-1:0] beam_cnt_q;
	logic [47:0]   moment_q;
	logic [31:0]   range_sum_q;
	logic signed [14:0] centroid_q;
	logic signed [16:0] prev_err_q;

	// divider
	logic [DIV_BITS-1:0] num_q;
	logic [43:0]         dvs_q;
	logic [43:0]         rem_q;
	logic [5:0]          div_cnt_q;

	// tick
	logic signed [16:0] err_q;
	logic signed [33:0] pterm_q;
	logic signed [34:0] dterm_q;

	// result
	logic               kind_q, empty_q, clamp_q;
	logic signed [15:0] steer_q;
	logic               out_valid_q;

	logic        [15:0] idx16;
	logic               in_win;
	logic        [31:0] prod;
	logic        [10:0] scale_eff;
	logic        [42:0] dprod;
	logic        [44:0] trial;
	logic               qbit;
	logic signed [63:0] cdiff;
	logic signed [14:0] cnew;
	logic signed [16:0] err_c;
	logic signed [17:0] derr;
	logic signed [39:0] u40;
	logic signed [39:0] urnd;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_begin_q   <= 11'd140;
			win_end_q     <= 11'd940;
			index_scale_q <= 11'd400;
			center_ofs_q  <= 15'sd5530;
			setpoint_q    <= 15'sd0;
			prop_gain_q   <= 16'd6963;
			deriv_gain_q  <= 16'd10240;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIN_BEGIN:   win_begin_q   <= cfg_data[10:0];
				REG_WIN_END:     win_end_q     <= cfg_data[10:0];
				REG_INDEX_SCALE: index_scale_q <= cfg_data[10:0];
				REG_CENTER_OFS:  center_ofs_q  <= cfg_data[14:0];
				REG_SETPOINT:    setpoint_q    <= cfg_data[14:0];
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// window test and moment product
	assign idx16  = 16'(beam_cnt_q);
	assign in_win = (idx16 >= 16'(win_begin_q)) && (idx16 < 16'(win_end_q));
	assign prod   = 32'(idx16) * 32'(range_value);

	// accumulation, beam counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_cnt_q  <= '0;
			moment_q    <= '0;
			range_sum_q <= '0;
		end else begin
			if (cmd.acc) begin
				if (in_win) begin
					range_sum_q <= range_sum_q + 32'(range_value);
					moment_q    <= moment_q + 48'(prod);
				end
				if (last_beam || beam_cnt_q == CW'(MAX_BEAMS - 1)) beam_cnt_q <= '0;
				else beam_cnt_q <= beam_cnt_q + 1'b1;
			end
			if (cmd.div_load || cmd.mark_empty) begin
				moment_q    <= '0;
				range_sum_q <= '0;
			end
		end
	end

	// divisor product, zero scale counts as one
	assign scale_eff = (index_scale_q == '0) ? 11'd1 : index_scale_q;
	assign dprod     = 43'(range_sum_q) * 43'(scale_eff);

	// restoring divider step
	assign trial = {rem_q, num_q[DIV_BITS-1]};
	assign qbit  = (trial >= 45'(dvs_q));

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q     <= {1'b0, moment_q, 13'd0} + DIV_BITS'(dprod);
			dvs_q     <= {dprod, 1'b0};
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= qbit ? 44'(trial - 45'(dvs_q)) : trial[43:0];
			num_q     <= {num_q[DIV_BITS-2:0], qbit};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// offset and saturate
	assign cdiff = $signed({2'b00, num_q}) - 64'(center_ofs_q);
	always_comb begin
		if (cdiff > 64'sd16383) cnew = 15'sd16383;
		else if (cdiff < -64'sd16384) cnew = -15'sd16384;
		else cnew = cdiff[14:0];
	end

	// PD terms
	assign err_c = 17'(centroid_q) - 17'(setpoint_q);
	assign derr  = 18'(err_q) - 18'(prev_err_q);
	assign u40   = 40'(pterm_q) + (40'(dterm_q) <<< 4);
	assign urnd  = (u40 + 40'sd512) >>> 10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centroid_q <= '0;
			prev_err_q <= '0;
		end else begin
			if (cmd.fin) centroid_q <= cnew;
			if (cmd.tick_u) prev_err_q <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_p) begin
			err_q   <= err_c;
			pterm_q <= $signed({1'b0, prop_gain_q}) * err_c;
		end
		if (cmd.tick_d) dterm_q <= $signed({1'b0, deriv_gain_q}) * derr;
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q  <= op;
			steer_q <= '0;
			clamp_q <= 1'b0;
			empty_q <= 1'b0;
		end
		if (cmd.mark_empty) empty_q <= 1'b1;
		if (cmd.tick_u) begin
			if (u40 > 40'sd16777216) begin
				steer_q <= 16'sd16384;
				clamp_q <= 1'b1;
			end else if (u40 < -40'sd16777216) begin
				steer_q <= -16'sd16384;
				clamp_q <= 1'b1;
			end else begin
				steer_q <= urnd[15:0];
				clamp_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			kind          <= kind_q;
			centroid_norm <= centroid_q;
			steering      <= steer_q;
			empty_scan    <= empty_q;
			clamped       <= clamp_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.range_zero = (range_sum_q == '0);
	assign sts.div_last   = (div_cnt_q == 6'(DIV_BITS - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

@@ rtl/core/scan_centroid_pd_steering.sv @@
// Scan centroid with PD steering. Each input word is a range sample (op=0) or
// a control tick (op=1). A sample that is not the last of its scan gives no
// output word. The last sample closes the scan: the window sums are divided by
// a restoring divider that yields one quotient bit per cycle in 62 divider
// steps, after setup and before the finish and output load states; an empty
// window skips the divider. A tick runs two registered multiplies and a clamp.
// Only one word is processed at a time; the finished output word sits in an
// output register so the next input is taken while it waits. Configuration
// writes take effect at once and belong between words.
module scan_centroid_pd_steering #(
	parameter int MAX_BEAMS = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [15:0]        range_value,
	input  logic               last_beam,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic signed [14:0] centroid_norm,
	output logic signed [15:0] steering,
	output logic               empty_scan,
	output logic               clamped
);
	import scpd_pkg::*;

	cmd_t    cmd;
	status_t sts;

	scpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.last_beam (last_beam),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	scpd_datapath #(.MAX_BEAMS(MAX_BEAMS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.range_value   (range_value),
		.last_beam     (last_beam),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.centroid_norm (centroid_norm),
		.steering      (steering),
		.empty_scan    (empty_scan),
		.clamped       (clamped),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

@@ rtl/core/scpd_checker.sv @@
module scpd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               kind,
	input logic signed [15:0] steering,
	input logic               empty_scan,
	input logic               clamped
);
	import scpd_pkg::*;

	// stalled output word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(steering) && $stable(kind))
		else $error("output word dropped while stalled");

	// scan reports carry no steering
	a_scan_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == OP_SAMPLE |-> steering == 16'sd0 && !clamped)
		else $error("steering fields set in scan report");

	// steering words never flag empty scan
	a_tick_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == OP_TICK |-> !empty_scan)
		else $error("empty flag on steering word");

	// steering stays within one
	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> steering <= 16'sd16384 && steering >= -16'sd16384)
		else $error("steering out of range");

	// clamping means a rail value
	a_clamp_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |-> steering == 16'sd16384 || steering == -16'sd16384)
		else $error("clamped without rail value");

endmodule

bind scan_centroid_pd_steering scpd_checker u_chk (.*);
